// File: sv/nisp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nisp_pkg
// Shared types and constants for the NVMe I/O submission and PRP builder.
// ============================================================================
package nisp_pkg;

    // Page geometry and PRP list limits.
    localparam int PAGE_BYTES           = 4096;
    localparam int PAGE_SHIFT           = 12;
    localparam int QUEUE_ENTRIES_DEF    = 64;
    localparam int MAX_LIST_ENTRIES_DEF = 63;
    localparam int DESC_FIFO_DEPTH_DEF  = 2;

    // Sector shift saturation bounds.
    localparam logic [4:0] SHIFT_MIN = 5'd9;
    localparam logic [4:0] SHIFT_MAX = 5'd16;

    // Field widths.
    localparam int DB_W    = 6;
    localparam int NPAGE_W = 6;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 336;

    // Input command codes.
    localparam logic [1:0] CMD_READ     = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_COMPLETE = 2'd2;

    // NVMe opcodes.
    localparam logic [7:0] OPC_WRITE = 8'h01;
    localparam logic [7:0] OPC_READ  = 8'h02;

    // Configuration register indexes.
    localparam logic CFG_SECTOR_SHIFT = 1'b0;
    localparam logic CFG_PRP_LIST     = 1'b1;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_CMD       = 3'd0,
        KIND_LIST      = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_NOT_READY = 3'd3,
        KIND_REJECT    = 3'd4
    } t_kind;

    // One input transaction, unpacked.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] nsid;
        logic [63:0] lba;
        logic [15:0] cnt;
        logic [63:0] buf_addr;
        logic [15:0] status;
    } t_req;

    // Classified work passed from the front end to the back end.
    typedef struct packed {
        t_kind               kind;
        logic [7:0]          opcode;
        logic [15:0]         cid;
        logic [31:0]         nsid;
        logic [63:0]         prp1;
        logic [63:0]         prp2;
        logic [63:0]         lba;
        logic [15:0]         cnt;
        logic [DB_W-1:0]     db;
        logic                success;
        logic [NPAGE_W-1:0]  npages;
        logic [63:0]         second;
    } t_desc;

    // One result transaction.
    typedef struct packed {
        t_kind           kind;
        logic [7:0]      opcode;
        logic [15:0]     cid;
        logic [31:0]     nsid;
        logic [63:0]     prp1;
        logic [63:0]     prp2;
        logic [63:0]     lba;
        logic [15:0]     cnt;
        logic [DB_W-1:0] db;
        logic [63:0]     page;
        logic            success;
        logic            last;
    } t_result;

endpackage

// File: sv/nisp_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// nisp_fifo
// Small register queue of work descriptors between front and back end.
// ============================================================================
module nisp_fifo
    import nisp_pkg::*;
#(
    parameter int DEPTH = DESC_FIFO_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PLAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CFULL = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CFULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PLAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PLAST) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("descriptor queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("descriptor queue read while empty");
`endif

endmodule

// File: sv/nisp_front.sv
`timescale 1ns / 1ps
// ============================================================================
// nisp_front
// Accepts requests, classifies them and keeps the queue pair state.
// ============================================================================
module nisp_front
    import nisp_pkg::*;
#(
    parameter int QUEUE_ENTRIES    = QUEUE_ENTRIES_DEF,
    parameter int MAX_LIST_ENTRIES = MAX_LIST_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_push,
    output t_desc       o_desc,
    input  logic        i_full
);

    localparam int QW = $clog2(QUEUE_ENTRIES);
    localparam logic [QW-1:0] QLAST = QW'(QUEUE_ENTRIES - 1);

    // Configuration registers.
    logic [4:0]  r_shift;
    logic [63:0] r_prp_list;

    // Queue pair state.
    logic [QW-1:0] r_tail;
    logic [QW-1:0] r_head;
    logic          r_phase;
    logic [15:0]   r_id;

    // Holding stage for the accepted request.
    logic        r_hold_valid;
    t_req        r_req;
    logic [32:0] r_tpo;

    logic [4:0]     sat_shift;
    logic [31:0]    total;
    logic           accept;
    logic           spans_two;
    logic           uses_list;
    logic [32:0]    tpo_m1;
    logic [20:0]    npages_full;
    logic           overlong;
    logic [63:0]    second;
    logic [63:0]    prp2;
    logic [QW-1:0]  tail_nx;
    logic [QW-1:0]  head_nx;
    logic [15:0]    id_nx;
    logic           phase_ok;
    logic [QW+DB_W-1:0] tail_ext;
    logic [QW+DB_W-1:0] head_ext;
    logic [QW+DB_W-1:0] head_nx_ext;
    logic           do_submit;
    logic           do_complete;

    assign o_ready = !r_hold_valid;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_hold_valid && !i_full;

    // Sector shift is clamped to the supported range before use.
    always_comb begin
        if (r_shift < SHIFT_MIN) begin
            sat_shift = SHIFT_MIN;
        end else if (r_shift > SHIFT_MAX) begin
            sat_shift = SHIFT_MAX;
        end else begin
            sat_shift = r_shift;
        end
    end

    // Transfer length in bytes; adding the page offset gives the byte count
    // measured from the start of the first page.
    assign total = 32'(i_req.cnt) << sat_shift;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= SHIFT_MIN;
            r_prp_list <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SECTOR_SHIFT: r_shift    <= i_cfg_data[4:0];
                CFG_PRP_LIST:     r_prp_list <= i_cfg_data;
                default:          r_shift    <= r_shift;
            endcase
        end
    end

    // Capture stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_tpo <= {1'b0, total} + {21'b0, i_req.buf_addr[PAGE_SHIFT-1:0]};
        end
    end

    // Page classification: more than one page if the span passes the first
    // page boundary, a list if it passes the second.
    assign spans_two   = (r_tpo > 33'(PAGE_BYTES));
    assign uses_list   = (r_tpo > 33'(2 * PAGE_BYTES));
    assign tpo_m1      = r_tpo - 33'd1;
    assign npages_full = tpo_m1[32:PAGE_SHIFT];
    assign overlong    = uses_list && (npages_full > 21'(MAX_LIST_ENTRIES));
    assign second      = {r_req.buf_addr[63:PAGE_SHIFT] + 52'd1, {PAGE_SHIFT{1'b0}}};

    always_comb begin
        if (!spans_two) begin
            prp2 = '0;
        end else if (!uses_list) begin
            prp2 = second;
        end else begin
            prp2 = r_prp_list;
        end
    end

    // Next queue indexes, wrapping at the queue size.
    assign tail_nx  = (r_tail == QLAST) ? '0 : r_tail + QW'(1);
    assign head_nx  = (r_head == QLAST) ? '0 : r_head + QW'(1);
    assign id_nx    = r_id + 16'd1;
    assign phase_ok = (r_req.status[0] == r_phase);

    assign tail_ext    = {{DB_W{1'b0}}, tail_nx};
    assign head_ext    = {{DB_W{1'b0}}, r_head};
    assign head_nx_ext = {{DB_W{1'b0}}, head_nx};

    // Descriptor build.
    always_comb begin
        o_desc      = '0;
        do_submit   = 1'b0;
        do_complete = 1'b0;
        unique case (r_req.cmd) inside
            CMD_READ, CMD_WRITE: begin
                if (r_req.cnt == 16'd0 || overlong) begin
                    o_desc.kind = KIND_REJECT;
                end else begin
                    do_submit     = 1'b1;
                    o_desc.kind   = KIND_CMD;
                    o_desc.opcode = (r_req.cmd == CMD_WRITE) ? OPC_WRITE : OPC_READ;
                    o_desc.cid    = id_nx;
                    o_desc.nsid   = r_req.nsid;
                    o_desc.prp1   = r_req.buf_addr;
                    o_desc.prp2   = prp2;
                    o_desc.lba    = r_req.lba;
                    o_desc.cnt    = r_req.cnt - 16'd1;
                    o_desc.db     = tail_ext[DB_W-1:0];
                    o_desc.npages = uses_list ? npages_full[NPAGE_W-1:0] : '0;
                    o_desc.second = second;
                end
            end
            CMD_COMPLETE: begin
                if (phase_ok) begin
                    do_complete    = 1'b1;
                    o_desc.kind    = KIND_DONE;
                    o_desc.db      = head_nx_ext[DB_W-1:0];
                    o_desc.success = (r_req.status[15:1] == 15'd0);
                end else begin
                    o_desc.kind = KIND_NOT_READY;
                    o_desc.db   = head_ext[DB_W-1:0];
                end
            end
            default: begin
                o_desc.kind = KIND_REJECT;
            end
        endcase
    end

    // Holding stage control and queue pair state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_tail       <= '0;
            r_head       <= '0;
            r_phase      <= 1'b1;
            r_id         <= '0;
        end else begin
            if (accept) begin
                r_hold_valid <= 1'b1;
            end else if (o_push) begin
                r_hold_valid <= 1'b0;
            end
            if (o_push && do_submit) begin
                r_tail <= tail_nx;
                r_id   <= id_nx;
            end
            if (o_push && do_complete) begin
                r_head <= head_nx;
                if (head_nx == '0) begin
                    r_phase <= !r_phase;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_phase_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_phase)) |-> (r_head == '0))
        else $error("expected phase changed without a head wrap");

    a_id_with_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_id)) |-> !$stable(r_tail))
        else $error("command id advanced without a tail advance");
`endif

endmodule

// File: sv/nisp_back.sv
`timescale 1ns / 1ps
// ============================================================================
// nisp_back
// Turns descriptors into result transactions, one per cycle while the
// output is not stalled, including the PRP list entries of long transfers.
// ============================================================================
module nisp_back
    import nisp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_desc   i_desc,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    typedef enum logic [1:0] {
        ST_HEAD = 2'b01,
        ST_LIST = 2'b10
    } t_bk_state;

    t_bk_state          r_state;
    logic               r_out_valid;
    t_result            r_out;
    logic [63:0]        r_page;
    logic [NPAGE_W-1:0] r_idx;
    logic [NPAGE_W-1:0] r_np;

    logic    slot_free;
    logic    list_last;
    t_result list_res;

    assign slot_free = !r_out_valid || i_ready;
    assign o_pop     = slot_free && (r_state == ST_HEAD) && !i_empty;
    assign list_last = (r_idx == r_np);
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // A list entry carries only its kind, the page address and last.
    always_comb begin
        list_res      = '0;
        list_res.kind = KIND_LIST;
        list_res.page = r_page;
        list_res.last = list_last;
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.kind    <= i_desc.kind;
            r_out.opcode  <= i_desc.opcode;
            r_out.cid     <= i_desc.cid;
            r_out.nsid    <= i_desc.nsid;
            r_out.prp1    <= i_desc.prp1;
            r_out.prp2    <= i_desc.prp2;
            r_out.lba     <= i_desc.lba;
            r_out.cnt     <= i_desc.cnt;
            r_out.db      <= i_desc.db;
            r_out.page    <= '0;
            r_out.success <= i_desc.success;
            r_out.last    <= (i_desc.npages == '0);
            r_page        <= i_desc.second;
            r_idx         <= NPAGE_W'(1);
            r_np          <= i_desc.npages;
        end else if (slot_free && r_state == ST_LIST) begin
            r_out  <= list_res;
            r_page <= r_page + 64'(PAGE_BYTES);
            r_idx  <= r_idx + NPAGE_W'(1);
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HEAD;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_HEAD: begin
                    if (o_pop) begin
                        r_out_valid <= 1'b1;
                        if (i_desc.npages != '0) begin
                            r_state <= ST_LIST;
                        end
                    end else if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_LIST: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        if (list_last) begin
                            r_state <= ST_HEAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_HEAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_list_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |-> (r_np != '0 && r_idx <= r_np))
        else $error("list sequencer index out of range");
`endif

endmodule

// File: sv/nvme_io_submit_prp_builder.sv
`timescale 1ns / 1ps
// ============================================================================
// nvme_io_submit_prp_builder
// Host-side NVMe I/O queue pair engine building command entries and PRP lists.
// ============================================================================
// In the front end each request is first registered and its byte span
// computed; it is then classified, the queue pair state is updated and a
// descriptor is placed in a two-entry queue. The back end emits one result
// transaction per cycle from that queue while the output is not stalled, so a
// read or write that needs a PRP list of N entries produces 1 + N results.
// The front end takes no new request until the held one is queued, and the
// back end, with its single output register, pops no new descriptor until
// the list entries are loaded. Results carry tlast on each final result.
module nvme_io_submit_prp_builder
    import nisp_pkg::*;
#(
    parameter int QUEUE_ENTRIES    = QUEUE_ENTRIES_DEF,
    parameter int MAX_LIST_ENTRIES = MAX_LIST_ENTRIES_DEF,
    parameter int DESC_FIFO_DEPTH  = DESC_FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // namespace_id[31:0], lba[95:32], num_sectors[111:96],
    // buffer_address[175:112], completion_status[191:176]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // opcode[7:0], cmd_tag[23:8], nsid_out[55:24], prp_first[119:56],
    // prp_second[183:120], lba_out[247:184], count_minus_one[263:248],
    // doorbell_value[269:264], page_address[333:270], success[334], zero[335]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // kind[2:0]
    output logic [2:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [63:0]           i_cfg_data
);

    t_req    req;
    t_desc   push_desc;
    t_desc   pop_desc;
    t_result res;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;

    // Unpack the input transaction.
    assign req.cmd      = i_s_axis_tuser;
    assign req.nsid     = i_s_axis_tdata[31:0];
    assign req.lba      = i_s_axis_tdata[95:32];
    assign req.cnt      = i_s_axis_tdata[111:96];
    assign req.buf_addr = i_s_axis_tdata[175:112];
    assign req.status   = i_s_axis_tdata[191:176];

    nisp_front #(
        .QUEUE_ENTRIES    (QUEUE_ENTRIES),
        .MAX_LIST_ENTRIES (MAX_LIST_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_req       (req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_desc      (push_desc),
        .i_full      (full)
    );

    nisp_fifo #(
        .DEPTH (DESC_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_desc),
        .o_empty (empty)
    );

    nisp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_desc   (pop_desc),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (res)
    );

    // Pack the result transaction.
    assign o_m_axis_tdata = {1'b0, res.success, res.page, res.db, res.cnt, res.lba,
                             res.prp2, res.prp1, res.nsid, res.cid, res.opcode};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule

// File: test/nvme_io_submit_prp_builder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// nvme_io_submit_prp_builder_tb
// Self-checking bench for the NVMe I/O submission and PRP builder. A table of
// directed requests runs first. Five phases of random requests follow, each
// under its own sector shift and PRP list address. Every accepted result is
// compared field by field against a predictor of the queue pair.
// ============================================================================
module nvme_io_submit_prp_builder_tb;
    import nisp_pkg::*;

    localparam int          CLK_HALF        = 5;
    localparam int          RESET_CYCLES    = 12;
    localparam int          RANDOM_PHASES   = 5;
    localparam int          ITEMS_PER_PHASE = 22;
    localparam int          SETTLE_CYCLES   = 20;
    localparam int          PRINT_LIMIT     = 200;
    localparam logic [1:0]  CMD_UNKNOWN     = 2'd3;
    localparam logic [63:0] ALL_ONES        = '1;

    // One row of the directed table, with an optional hand-written result.
    typedef struct packed {
        t_req            req;
        logic            typed;
        t_kind           tkind;
        logic [DB_W-1:0] tdb;
        logic            tok;
    } t_row;

    logic                  i_clk;
    logic                  rst_n;
    logic                  s_valid;
    logic [IN_DATA_W-1:0]  s_data;
    logic [1:0]            s_user;
    logic                  m_ready;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [63:0]           cfg_data;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [2:0]            o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    // Shadow copy of the registers and the queue pair state.
    logic [4:0]  shift_reg;
    logic [63:0] list_addr;
    int          sub_tail;
    int          cpl_head;
    int          id_ctr;
    logic        exp_phase;

    t_result     pending_results[$];
    t_row        directed_rows[$];
    int          errors;
    bit          idle_en;
    int          stall_left;

    nvme_io_submit_prp_builder dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Free-running clock.
    always #(CLK_HALF) i_clk = ~i_clk;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < PRINT_LIMIT)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want,
                     $time);
        errors++;
    endtask

    // Works out the results of one accepted request and updates the shadow state.
    task automatic predict_request(input t_req rq);
        logic [4:0]  sh;
        logic [63:0] total;
        logic [63:0] head_bytes;
        logic [63:0] rem;
        logic [63:0] second;
        logic [63:0] prp2;
        logic [63:0] npages;
        t_result     r;
        int          i;
        sh = shift_reg;
        if (sh < SHIFT_MIN) sh = SHIFT_MIN;
        if (sh > SHIFT_MAX) sh = SHIFT_MAX;
        r = '0;
        r.last = 1'b1;
        case (rq.cmd)
            CMD_READ, CMD_WRITE: begin
                prp2   = '0;
                second = '0;
                npages = '0;
                total  = 64'(rq.cnt) << sh;
                head_bytes = 64'(PAGE_BYTES) - (rq.buf_addr & 64'(PAGE_BYTES - 1));
                if (total > head_bytes) begin
                    rem    = total - head_bytes;
                    second = rq.buf_addr + head_bytes;
                    if (rem <= 64'(PAGE_BYTES)) begin
                        prp2 = second;
                    end else begin
                        npages = (rem + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES);
                        prp2   = list_addr;
                    end
                end
                if (rq.cnt == 16'd0 || npages > 64'(MAX_LIST_ENTRIES_DEF)) begin
                    r.kind = KIND_REJECT;
                    pending_results.push_back(r);
                end else begin
                    id_ctr   = (id_ctr + 1) % 65536;
                    sub_tail = (sub_tail + 1) % QUEUE_ENTRIES_DEF;
                    r.kind   = KIND_CMD;
                    r.opcode = (rq.cmd == CMD_WRITE) ? OPC_WRITE : OPC_READ;
                    r.cid    = 16'(id_ctr);
                    r.nsid   = rq.nsid;
                    r.prp1   = rq.buf_addr;
                    r.prp2   = prp2;
                    r.lba    = rq.lba;
                    r.cnt    = rq.cnt - 16'd1;
                    r.db     = DB_W'(sub_tail);
                    r.last   = (npages == 0);
                    pending_results.push_back(r);
                    // One list entry per data page after the first.
                    for (i = 0; i < int'(npages); i++) begin
                        r      = '0;
                        r.kind = KIND_LIST;
                        r.page = second + 64'(i) * 64'(PAGE_BYTES);
                        r.last = (i == int'(npages) - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            CMD_COMPLETE: begin
                if (rq.status[0] != exp_phase) begin
                    r.kind = KIND_NOT_READY;
                    r.db   = DB_W'(cpl_head);
                end else begin
                    cpl_head = (cpl_head + 1) % QUEUE_ENTRIES_DEF;
                    if (cpl_head == 0) exp_phase = ~exp_phase;
                    r.kind    = KIND_DONE;
                    r.db      = DB_W'(cpl_head);
                    r.success = (rq.status[15:1] == '0);
                end
                pending_results.push_back(r);
            end
            default: begin
                r.kind = KIND_REJECT;
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Appends one row to the directed table.
    task automatic add_row(input logic [1:0] cmd, input logic [31:0] nsid,
                           input logic [63:0] lba, input logic [15:0] cnt,
                           input logic [63:0] addr, input logic [15:0] status,
                           input logic typed, input t_kind k,
                           input logic [DB_W-1:0] db, input logic ok);
        t_row row;
        row.req.cmd      = cmd;
        row.req.nsid     = nsid;
        row.req.lba      = lba;
        row.req.cnt      = cnt;
        row.req.buf_addr = addr;
        row.req.status   = status;
        row.typed        = typed;
        row.tkind        = k;
        row.tdb          = db;
        row.tok          = ok;
        directed_rows.push_back(row);
    endtask

    // Builds a random request, mostly with transfers small enough to be accepted.
    function automatic t_req make_random_request();
        t_req        rq;
        int          p;
        int          eff;
        logic [63:0] addr;
        eff = int'(shift_reg);
        if (eff < int'(SHIFT_MIN)) eff = int'(SHIFT_MIN);
        if (eff > int'(SHIFT_MAX)) eff = int'(SHIFT_MAX);
        rq.nsid   = $urandom;
        rq.lba    = {$urandom, $urandom};
        rq.status = 16'($urandom);
        p = $urandom_range(0, 99);
        if (p < 48) rq.cmd = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
        else if (p < 96) rq.cmd = CMD_COMPLETE;
        else rq.cmd = CMD_UNKNOWN;
        p = $urandom_range(0, 99);
        if (p < 3) rq.cnt = '0;
        else if (p < 8) rq.cnt = 16'($urandom_range(0, 65535));
        else if (p < 80) rq.cnt = 16'($urandom_range(1, (16384 >> eff) + 1));
        else rq.cnt = 16'($urandom_range(1, 266240 >> eff));
        addr = {$urandom, $urandom};
        p = $urandom_range(0, 99);
        if (p < 25) addr[11:0] = '0;
        else if (p < 40) addr[11:0] = 12'($urandom_range(12'hF00, 12'hFFF));
        rq.buf_addr = addr;
        // Completions mostly carry the phase that the queue expects.
        if (rq.cmd == CMD_COMPLETE) begin
            rq.status[0] = ($urandom_range(0, 15) == 0) ? ~exp_phase : exp_phase;
            if ($urandom_range(0, 1) == 1) rq.status[15:1] = '0;
        end
        return rq;
    endfunction

    // Presents one request and waits until it is accepted.
    task automatic send_request(input t_req rq, input logic typed, input t_result typed_res);
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= {rq.status, rq.buf_addr, rq.cnt, rq.lba, rq.nsid};
        s_user  <= rq.cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_request(rq);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
    endtask

    // Random idle burst on the sending side.
    task automatic sender_gap();
        int n;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic wait_drain();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Configuration write, mirrored into the shadow registers.
    task automatic write_reg(input logic idx, input logic [63:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SECTOR_SHIFT) shift_reg = value[4:0];
        else list_addr = value;
    endtask

    // Result side back-pressure in random bursts.
    always @(negedge i_clk) begin
        logic ready_next;
        if (idle_en && stall_left > 0) begin
            stall_left = stall_left - 1;
            ready_next = 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_ready <= ready_next;
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            got.kind    = t_kind'(o_m_axis_tuser);
            got.opcode  = o_m_axis_tdata[7:0];
            got.cid     = o_m_axis_tdata[23:8];
            got.nsid    = o_m_axis_tdata[55:24];
            got.prp1    = o_m_axis_tdata[119:56];
            got.prp2    = o_m_axis_tdata[183:120];
            got.lba     = o_m_axis_tdata[247:184];
            got.cnt     = o_m_axis_tdata[263:248];
            got.db      = o_m_axis_tdata[269:264];
            got.page    = o_m_axis_tdata[333:270];
            got.success = o_m_axis_tdata[334];
            got.last    = o_m_axis_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, kind", 64'(got.kind), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
                if (got.opcode !== want.opcode)
                    report_mismatch("opcode", got.opcode, want.opcode);
                if (got.cid !== want.cid) report_mismatch("cmd_tag", got.cid, want.cid);
                if (got.nsid !== want.nsid) report_mismatch("nsid_out", got.nsid, want.nsid);
                if (got.prp1 !== want.prp1) report_mismatch("prp_first", got.prp1, want.prp1);
                if (got.prp2 !== want.prp2)
                    report_mismatch("prp_second", got.prp2, want.prp2);
                if (got.lba !== want.lba) report_mismatch("lba_out", got.lba, want.lba);
                if (got.cnt !== want.cnt)
                    report_mismatch("count_minus_one", got.cnt, want.cnt);
                if (got.db !== want.db) report_mismatch("doorbell_value", got.db, want.db);
                if (got.page !== want.page)
                    report_mismatch("page_address", got.page, want.page);
                if (got.success !== want.success)
                    report_mismatch("success", got.success, want.success);
                if (got.last !== want.last) report_mismatch("last", got.last, want.last);
                if (o_m_axis_tdata[OUT_DATA_W-1] !== 1'b0)
                    report_mismatch("pad", o_m_axis_tdata[OUT_DATA_W-1], '0);
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int          k;
        int          ph;
        int          n;
        t_result     typed_res;
        logic [63:0] value;
        i_clk      = 1'b0;
        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        s_user     = '0;
        m_ready    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SECTOR_SHIFT;
        cfg_data   = '0;
        shift_reg  = 5'd9;
        list_addr  = '0;
        sub_tail   = 0;
        cpl_head   = 0;
        id_ctr     = 0;
        exp_phase  = 1'b1;
        errors     = 0;
        idle_en    = 1'b1;
        stall_left = 0;

        // Directed table, run with the register values from reset.
        add_row(CMD_COMPLETE, '0, '0, '0, '0, 16'h0000, 1'b1, KIND_NOT_READY, 6'd0, 1'b0);
        add_row(CMD_UNKNOWN, '0, '0, 16'd1, '0, '0, 1'b1, KIND_REJECT, 6'd0, 1'b0);
        add_row(CMD_READ, 32'h1, 64'h10, 16'd0, 64'h1000, '0, 1'b1, KIND_REJECT, 6'd0, 1'b0);
        add_row(CMD_READ, '0, '0, 16'd1, '0, '0, 1'b0, KIND_CMD, 6'd0, 1'b0);
        add_row(CMD_WRITE, 32'h7, 64'h1, 16'd8, '0, '0, 1'b0, KIND_CMD, 6'd0, 1'b0);
        add_row(CMD_WRITE, 32'h8, 64'h2, 16'd9, '0, '0, 1'b0, KIND_CMD, 6'd0, 1'b0);
        add_row(CMD_WRITE, 32'h9, 64'h3, 16'd16, 64'h2000, '0, 1'b0, KIND_CMD, 6'd0, 1'b0);
        add_row(CMD_READ, 32'hA, 64'h4, 16'd16, 64'hF00, '0, 1'b0, KIND_CMD, 6'd0, 1'b0);
        // Longest list that fits, then one page too many.
        add_row(CMD_READ, 32'hB, 64'h5, 16'd512, 64'h1000, '0, 1'b0, KIND_CMD, 6'd0, 1'b0);
        add_row(CMD_WRITE, 32'hC, 64'h6, 16'd513, 64'h1000, '0, 1'b1, KIND_REJECT, 6'd0,
                1'b0);
        add_row(CMD_READ, 32'hD, 64'h7, 16'hFFFF, 64'h1234_5678, '0, 1'b1, KIND_REJECT, 6'd0,
                1'b0);
        // Address arithmetic that wraps through zero.
        add_row(CMD_READ, 32'hFFFF_FFFF, ALL_ONES, 16'd1, ALL_ONES, '0, 1'b0, KIND_CMD, 6'd0,
                1'b0);
        add_row(CMD_WRITE, 32'h5A5A_A5A5, 64'h8000_0000_0000_0000, 16'd64,
                64'hFFFF_FFFF_FFFF_F000, 16'hFFFF, 1'b0, KIND_CMD, 6'd0, 1'b0);
        add_row(CMD_COMPLETE, '0, '0, '0, '0, 16'h0001, 1'b1, KIND_DONE, 6'd1, 1'b1);
        add_row(CMD_COMPLETE, '0, '0, '0, '0, 16'hFFFF, 1'b1, KIND_DONE, 6'd2, 1'b0);
        add_row(CMD_COMPLETE, ALL_ONES[31:0], ALL_ONES, 16'hFFFF, ALL_ONES, 16'hFFFE, 1'b1,
                KIND_NOT_READY, 6'd2, 1'b0);
        add_row(CMD_UNKNOWN, ALL_ONES[31:0], ALL_ONES, 16'hFFFF, ALL_ONES, 16'hFFFF, 1'b1,
                KIND_REJECT, 6'd0, 1'b0);
        add_row(CMD_COMPLETE, '0, '0, '0, '0, 16'h0003, 1'b1, KIND_DONE, 6'd3, 1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        for (k = 0; k < directed_rows.size(); k++) begin
            typed_res         = '0;
            typed_res.kind    = directed_rows[k].tkind;
            typed_res.db      = directed_rows[k].tdb;
            typed_res.success = directed_rows[k].tok;
            typed_res.last    = 1'b1;
            send_request(directed_rows[k].req, directed_rows[k].typed, typed_res);
            sender_gap();
        end

        // Random phases, each under new register settings written while idle.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drain();
            case (ph)
                0: begin
                    write_reg(CFG_SECTOR_SHIFT, 64'd16);
                    write_reg(CFG_PRP_LIST, ALL_ONES);
                end
                1: begin
                    write_reg(CFG_SECTOR_SHIFT, 64'd0);
                    write_reg(CFG_PRP_LIST, '0);
                end
                2: begin
                    value = {$urandom, $urandom};
                    value[4:0] = 5'd31;
                    write_reg(CFG_SECTOR_SHIFT, value);
                    write_reg(CFG_PRP_LIST, {$urandom, $urandom});
                end
                3: begin
                    write_reg(CFG_SECTOR_SHIFT, 64'($urandom_range(9, 16)));
                    write_reg(CFG_PRP_LIST, {$urandom, $urandom});
                end
                default: begin
                    value = {$urandom, $urandom};
                    write_reg(CFG_SECTOR_SHIFT, value);
                    write_reg(CFG_PRP_LIST, {$urandom, $urandom});
                end
            endcase
            // The last phase runs at full rate on both sides.
            idle_en = (ph != RANDOM_PHASES - 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_request(make_random_request(), 1'b0, '0);
                sender_gap();
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
sv/nisp_pkg.sv
sv/nisp_fifo.sv
sv/nisp_front.sv
sv/nisp_back.sv
sv/nvme_io_submit_prp_builder.sv
test/nvme_io_submit_prp_builder_tb.sv
